@@ rtl/rectangle_raster_canvas_macros.svh @@
// ----------------------------------------------------------------------------
// Rectangle raster canvas assertion macros
// Shared property forms for the canvas port checker.
// ----------------------------------------------------------------------------
`ifndef RECTANGLE_RASTER_CANVAS_MACROS_SVH
`define RECTANGLE_RASTER_CANVAS_MACROS_SVH

// The antecedent at one edge implies the consequent at the next edge.
`define RRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rectangle_raster_canvas: next-cycle check failed");

// The antecedent implies the consequent at the same edge.
`define RRC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rectangle_raster_canvas: same-cycle check failed");

`endif

@@ rtl/rrc_pkg.sv @@
// ----------------------------------------------------------------------------
// Rectangle raster canvas package
// Sizes, request and status codes, and shared types of the canvas block.
// ----------------------------------------------------------------------------
package rrc_pkg;

  localparam int MAX_SIDE  = 256;
  localparam int ADDR_W    = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int SIDE_W    = $clog2(MAX_SIDE) + 1;
  localparam int COORD_W   = 32;
  localparam int EXT_W     = COORD_W + 2;
  localparam int FRAC_BITS = 8;
  localparam int CELL_W    = EXT_W - FRAC_BITS;
  localparam int ONE_FIX   = 1 << FRAC_BITS;
  localparam int CFG_W     = SIDE_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_DRAW  = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_RECT  = 2'd1;
  localparam logic [1:0] STATUS_OUT_RANGE = 2'd2;

  localparam logic [7:0] KIND_OUTLINE = 8'h72;
  localparam logic [7:0] KIND_FILLED  = 8'h52;

  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND    = 2'd2;

  localparam logic [7:0] BACKGROUND_RESET = 8'h20;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP_SUM,
    ST_SETUP_CELL,
    ST_SCAN,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic sum;
    logic quant;
  } bnd_ctrl_t;

endpackage

@@ rtl/rrc_mem.sv @@
// ----------------------------------------------------------------------------
// Canvas memory
// Single-port byte store for the canvas, with a registered read.
// ----------------------------------------------------------------------------
module rrc_mem (
  input  logic                      clk,
  input  logic                      we,
  input  logic                      re,
  input  logic [rrc_pkg::ADDR_W-1:0] addr,
  input  logic [7:0]                wdata,
  output logic [7:0]                rdata
);
  import rrc_pkg::*;

  logic [7:0] store [MAX_SIDE*MAX_SIDE];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      store[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= store[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/rrc_bounds.sv @@
// ----------------------------------------------------------------------------
// Rectangle bounds unit
// Turns the fixed-point rectangle into integer pixel bounds and tests pixels.
// ----------------------------------------------------------------------------
module rrc_bounds (
  input  logic                        clk,
  input  rrc_pkg::bnd_ctrl_t          ctrl,
  input  logic [7:0]                  rect_kind,
  input  logic [rrc_pkg::COORD_W-1:0] rect_x,
  input  logic [rrc_pkg::COORD_W-1:0] rect_y,
  input  logic [rrc_pkg::COORD_W-1:0] rect_width,
  input  logic [rrc_pkg::COORD_W-1:0] rect_height,
  input  logic [rrc_pkg::SIDE_W-1:0]  col,
  input  logic [rrc_pkg::SIDE_W-1:0]  row,
  output logic                        paint
);
  import rrc_pkg::*;

  logic signed [EXT_W-1:0]  x0_r, y0_r, rw_r, rh_r;
  logic signed [EXT_W-1:0]  xlo_sum_r, ylo_sum_r, x1_r, y1_r;
  logic signed [CELL_W-1:0] xlo_r, xhi_r, ylo_r, yhi_r;
  logic                     filled_r;
  logic signed [CELL_W-1:0] col_s, row_s;
  logic                     in_x, in_y, edge_x, edge_y;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x0_r     <= EXT_W'($signed(rect_x));
      y0_r     <= EXT_W'($signed(rect_y));
      rw_r     <= EXT_W'($signed(rect_width));
      rh_r     <= EXT_W'($signed(rect_height));
      filled_r <= (rect_kind == KIND_FILLED);
    end
    // A pixel at p*ONE_FIX is right of x0 when p >= ceil(x0 / ONE_FIX).
    if (ctrl.sum) begin
      xlo_sum_r <= x0_r + EXT_W'(ONE_FIX - 1);
      ylo_sum_r <= y0_r + EXT_W'(ONE_FIX - 1);
      x1_r      <= x0_r + rw_r;
      y1_r      <= y0_r + rh_r;
    end
    if (ctrl.quant) begin
      xlo_r <= CELL_W'(xlo_sum_r >>> FRAC_BITS);
      ylo_r <= CELL_W'(ylo_sum_r >>> FRAC_BITS);
      xhi_r <= CELL_W'(x1_r >>> FRAC_BITS);
      yhi_r <= CELL_W'(y1_r >>> FRAC_BITS);
    end
  end

  assign col_s = $signed({{(CELL_W-SIDE_W){1'b0}}, col});
  assign row_s = $signed({{(CELL_W-SIDE_W){1'b0}}, row});

  // With integer bounds, the border is exactly the first and last column or row.
  always_comb begin
    in_x   = (col_s >= xlo_r) && (col_s <= xhi_r);
    in_y   = (row_s >= ylo_r) && (row_s <= yhi_r);
    edge_x = (col_s == xlo_r) || (col_s == xhi_r);
    edge_y = (row_s == ylo_r) || (row_s == yhi_r);
    paint  = in_x && in_y && (filled_r || edge_x || edge_y);
  end

endmodule

@@ rtl/rectangle_raster_canvas.sv @@
// ----------------------------------------------------------------------------
// Rectangle raster canvas
// Byte canvas in one single-port memory; clears, draws rectangles, reads pixels.
// ----------------------------------------------------------------------------
// A valid draw sets up its bounds before it sweeps; a read forms its address
// and then reads the memory; an invalid draw or unused request goes straight to the result.
// Clear and draw sweep the canvas memory at one pixel per cycle, so the
// memory write port sets the rate; one item is handled at a time.
// Result strobe out_valid is high for one cycle; busy falls the cycle after.
// Synchronous reset returns to idle with size 0 and background 0x20; the
// canvas memory itself is not cleared.
module rectangle_raster_canvas (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_req_type,
  input  logic [7:0]                    in_rect_kind,
  input  logic [rrc_pkg::COORD_W-1:0]   in_rect_x,
  input  logic [rrc_pkg::COORD_W-1:0]   in_rect_y,
  input  logic [rrc_pkg::COORD_W-1:0]   in_rect_width,
  input  logic [rrc_pkg::COORD_W-1:0]   in_rect_height,
  input  logic [7:0]                    in_paint_color,
  input  logic [7:0]                    in_read_col,
  input  logic [7:0]                    in_read_row,
  output logic                          out_valid,
  output logic [7:0]                    out_pixel_value,
  output logic [1:0]                    out_status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rrc_pkg::CFG_W-1:0]     cfg_data
);
  import rrc_pkg::*;

  state_t              state_r, state_nxt;
  logic [SIDE_W-1:0]   cw_r, ch_r;
  logic [7:0]          bg_r;
  logic [SIDE_W-1:0]   col_r, col_nxt, row_r, row_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [1:0]          status_r, status_nxt;
  logic                rd_ok_r, rd_ok_nxt;
  logic                clear_r, clear_nxt;
  logic [7:0]          color_r, color_nxt;
  logic [7:0]          rcol_r, rcol_nxt, rrow_r, rrow_nxt;

  logic [SIDE_W-1:0]   eff_w, eff_h;
  logic                accept, bad_rect, paint;
  logic                mem_we, mem_re;
  logic [7:0]          mem_wdata, mem_rdata;
  logic [ADDR_W-1:0]   rd_addr_full;
  bnd_ctrl_t           bnd_ctrl;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign eff_w = (cw_r > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : cw_r;
  assign eff_h = (ch_r > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : ch_r;

  assign bad_rect = in_rect_width[COORD_W-1] || (in_rect_width == '0) ||
                    in_rect_height[COORD_W-1] || (in_rect_height == '0) ||
                    !(in_rect_kind inside {KIND_OUTLINE, KIND_FILLED});

  // Row and column are both below the side, so the address fits the store.
  assign rd_addr_full = ADDR_W'(rrow_r) * ADDR_W'(eff_w) + ADDR_W'(rcol_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r <= '0;
      ch_r <= '0;
      bg_r <= BACKGROUND_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CANVAS_WIDTH:  cw_r <= cfg_data;
        CFG_CANVAS_HEIGHT: ch_r <= cfg_data;
        CFG_BACKGROUND:    bg_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r    <= col_nxt;
    row_r    <= row_nxt;
    addr_r   <= addr_nxt;
    status_r <= status_nxt;
    rd_ok_r  <= rd_ok_nxt;
    clear_r  <= clear_nxt;
    color_r  <= color_nxt;
    rcol_r   <= rcol_nxt;
    rrow_r   <= rrow_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    addr_nxt   = addr_r;
    status_nxt = status_r;
    rd_ok_nxt  = rd_ok_r;
    clear_nxt  = clear_r;
    color_nxt  = color_r;
    rcol_nxt   = rcol_r;
    rrow_nxt   = rrow_r;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_wdata  = clear_r ? bg_r : color_r;
    bnd_ctrl   = '{load: accept, sum: 1'b0, quant: 1'b0};

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          col_nxt    = '0;
          row_nxt    = '0;
          addr_nxt   = '0;
          status_nxt = STATUS_OK;
          rd_ok_nxt  = 1'b0;
          clear_nxt  = (in_req_type == REQ_CLEAR);
          color_nxt  = in_paint_color;
          rcol_nxt   = in_read_col;
          rrow_nxt   = in_read_row;
          case (in_req_type)
            REQ_CLEAR: begin
              state_nxt = ((eff_w == '0) || (eff_h == '0)) ? ST_DONE : ST_SCAN;
            end
            REQ_DRAW: begin
              if (bad_rect) begin
                status_nxt = STATUS_BAD_RECT;
                state_nxt  = ST_DONE;
              end else begin
                state_nxt = ST_SETUP_SUM;
              end
            end
            REQ_READ: begin
              if ((SIDE_W'(in_read_col) >= eff_w) || (SIDE_W'(in_read_row) >= eff_h)) begin
                status_nxt = STATUS_OUT_RANGE;
                state_nxt  = ST_DONE;
              end else begin
                rd_ok_nxt = 1'b1;
                state_nxt = ST_RD_ADDR;
              end
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SETUP_SUM: begin
        bnd_ctrl.sum = 1'b1;
        state_nxt    = ST_SETUP_CELL;
      end
      ST_SETUP_CELL: begin
        bnd_ctrl.quant = 1'b1;
        // An empty canvas has nothing to paint.
        state_nxt = ((eff_w == '0) || (eff_h == '0)) ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        mem_we   = clear_r || paint;
        addr_nxt = addr_r + 1'b1;
        if (col_r == eff_w - 1'b1) begin
          col_nxt = '0;
          if (row_r == eff_h - 1'b1) begin
            state_nxt = ST_DONE;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      ST_RD_ADDR: begin
        addr_nxt  = rd_addr_full;
        state_nxt = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        mem_re    = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid       = (state_r == ST_DONE);
  assign out_status      = status_r;
  assign out_pixel_value = rd_ok_r ? mem_rdata : 8'h00;

  rrc_bounds u_bounds (
    .clk         (clk),
    .ctrl        (bnd_ctrl),
    .rect_kind   (in_rect_kind),
    .rect_x      (in_rect_x),
    .rect_y      (in_rect_y),
    .rect_width  (in_rect_width),
    .rect_height (in_rect_height),
    .col         (col_r),
    .row         (row_r),
    .paint       (paint)
  );

  rrc_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (addr_r),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

@@ rtl/rrc_checker.sv @@
// ----------------------------------------------------------------------------
// Rectangle raster canvas port checker
// Checks the result strobe and busy sequencing seen on the top-level ports.
// ----------------------------------------------------------------------------
`include "rectangle_raster_canvas_macros.svh"

module rrc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [7:0] out_pixel_value,
  input logic [1:0] out_status
);
  import rrc_pkg::*;

  // Every accepted item makes the block busy in the cycle after it is accepted.
  `RRC_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // A result belongs to an item still in flight, and the block then frees up.
  `RRC_ASSERT_SAME(a_valid_busy, out_valid, busy)
  `RRC_ASSERT_NEXT(a_valid_release, out_valid, !busy && !out_valid)
  // Error results never carry a pixel byte.
  `RRC_ASSERT_SAME(a_err_zero, out_valid && (out_status != STATUS_OK), out_pixel_value == 8'h00)

endmodule

bind rectangle_raster_canvas rrc_checker u_rrc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_pixel_value (out_pixel_value),
  .out_status      (out_status)
);
